### rtl/core/tklt_pkg.sv
// ----------------------------------------------------------------------------
// tklt_pkg - shared types and constants
// Entry record, register indexes, request kinds and list fill values.
// ----------------------------------------------------------------------------
package tklt_pkg;

    typedef struct packed {
        logic signed [31:0] score;
        logic signed [31:0] order;
        logic [15:0]        tag;
    } entry_t;

    // configuration register indexes
    localparam logic REG_HIGH_COUNT = 1'b0;
    localparam logic REG_LOW_COUNT  = 1'b1;

    // request kinds
    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // read list selector
    localparam logic LIST_HIGH = 1'b0;
    localparam logic LIST_LOW  = 1'b1;

    localparam logic [4:0] COUNT_RESET = 5'd16;

    localparam logic signed [31:0] LOW_SCORE_FILL = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LOW_ORDER_FILL = 32'sh6363_6363;

endpackage

### rtl/core/tklt_cell.sv
// ----------------------------------------------------------------------------
// tklt_cell - one slot of a sorted insertion list
// Holds one entry; on an offer it keeps, takes the candidate or takes the
// entry handed down by its upper neighbour.
// ----------------------------------------------------------------------------
module tklt_cell #(
    parameter bit IS_LOW = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,        // offer accepted this cycle
    input  logic            en,          // slot lies within the count in use
    input  tklt_pkg::entry_t cand,
    input  tklt_pkg::entry_t prev_entry, // entry of the neighbour above
    input  logic            prev_beats,  // candidate beat the neighbour above
    output tklt_pkg::entry_t entry,
    output logic            beats
);

    tklt_pkg::entry_t entry_reg, entry_next;

    // strict compare keeps earlier entries ahead on ties
    always_comb
    begin
        if (IS_LOW)
            beats = en && (entry_reg.score > cand.score);
        else
            beats = en && (entry_reg.score < cand.score);
    end

    // list stays sorted, so a beaten neighbour means this slot is beaten too
    always_comb
    begin
        entry_next = entry_reg;
        if (load && en)
        begin
            if (prev_beats)
                entry_next = prev_entry;
            else if (beats)
                entry_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            if (IS_LOW)
            begin
                entry_reg.score <= tklt_pkg::LOW_SCORE_FILL;
                entry_reg.order <= tklt_pkg::LOW_ORDER_FILL;
            end
            else
            begin
                entry_reg.score <= '0;
                entry_reg.order <= '0;
            end
            entry_reg.tag <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

### rtl/core/top_k_highest_lowest_tracker.sv
// ----------------------------------------------------------------------------
// top_k_highest_lowest_tracker - top-k highest / lowest score tracker
// Two sorted lists of scored candidates built as rows of insertion cells.
// ----------------------------------------------------------------------------
// The block keeps the MAX_KEPT highest scores (descending) and the MAX_KEPT
// lowest scores (ascending), each as a row of cells. An offer request is
// broadcast to every cell; each cell compares the candidate with its own
// entry and, in the same cycle, either keeps it, takes the candidate or takes
// the entry of the cell above, so the list shifts down behind the insertion
// point and the last entry in use drops out. A read request returns one
// stored entry. The result of each request sits in an output register; a
// new request is taken while that result is taken or the register is empty,
// so the sustained rate is one request per cycle while the receiver does not
// stall, set by the single compare-and-shift step of the cells. Scores are
// signed Q16.16; ties keep earlier entries ahead. Counts of 0 act as 1, counts
// above MAX_KEPT act as MAX_KEPT. Configuration writes are taken at any time
// but must only be made while no request is in flight.
// ----------------------------------------------------------------------------
module top_k_highest_lowest_tracker #(
    parameter int MAX_KEPT = 16,
    parameter int TAG_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_wdata,

    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // score[31:0], order[63:32], tag[79:64],
                                  // read_index[83:80], zero[87:84]
    input  logic [1:0]  s_tuser,  // action[0], read_list[1]

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata   // high_inserted[0], high_position[4:1],
                                  // low_inserted[5], low_position[9:6],
                                  // entry_score[41:10], entry_order[73:42],
                                  // entry_tag[89:74], zero[95:90]
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int NW = (CW > 5) ? CW : 5;
    localparam logic [15:0] TAG_MASK =
        (TAG_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << TAG_BITS) - 32'd1);

    // ---------------------------------------------------------------- config
    logic [4:0] high_count_reg, low_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_count_reg <= tklt_pkg::COUNT_RESET;
            low_count_reg  <= tklt_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tklt_pkg::REG_HIGH_COUNT: high_count_reg <= cfg_wdata;
                tklt_pkg::REG_LOW_COUNT:  low_count_reg  <= cfg_wdata;
                default:                  high_count_reg <= high_count_reg;
            endcase
        end
    end

    // clamp counts into 1..MAX_KEPT
    logic [NW-1:0] high_n, low_n;

    always_comb
    begin
        if (high_count_reg == 5'd0)
            high_n = NW'(1);
        else if (NW'(high_count_reg) > NW'(MAX_KEPT))
            high_n = NW'(MAX_KEPT);
        else
            high_n = NW'(high_count_reg);

        if (low_count_reg == 5'd0)
            low_n = NW'(1);
        else if (NW'(low_count_reg) > NW'(MAX_KEPT))
            low_n = NW'(MAX_KEPT);
        else
            low_n = NW'(low_count_reg);
    end

    // -------------------------------------------------------- request fields
    logic             req_action, req_list;
    logic [3:0]       req_index;
    tklt_pkg::entry_t cand;

    assign req_action = s_tuser[0];
    assign req_list   = s_tuser[1];
    assign req_index  = s_tdata[83:80];
    assign cand.score = s_tdata[31:0];
    assign cand.order = s_tdata[63:32];
    assign cand.tag   = s_tdata[79:64] & TAG_MASK;

    logic accept, offer_load;
    assign accept     = s_tvalid && s_tready;
    assign offer_load = accept && (req_action == tklt_pkg::ACT_OFFER);

    // ------------------------------------------------------------ cell rows
    tklt_pkg::entry_t high_entry [MAX_KEPT];
    tklt_pkg::entry_t low_entry  [MAX_KEPT];
    logic [MAX_KEPT-1:0] high_beats, low_beats, high_en, low_en;

    for (genvar i = 0; i < MAX_KEPT; i++)
    begin : g_cells
        assign high_en[i] = NW'(i) < high_n;
        assign low_en[i]  = NW'(i) < low_n;

        if (i == 0)
        begin : g_head
            tklt_cell #(.IS_LOW(1'b0)) u_high (
                .clk(clk), .rst_n(rst_n), .load(offer_load), .en(high_en[i]),
                .cand(cand), .prev_entry(cand), .prev_beats(1'b0),
                .entry(high_entry[i]), .beats(high_beats[i])
            );
            tklt_cell #(.IS_LOW(1'b1)) u_low (
                .clk(clk), .rst_n(rst_n), .load(offer_load), .en(low_en[i]),
                .cand(cand), .prev_entry(cand), .prev_beats(1'b0),
                .entry(low_entry[i]), .beats(low_beats[i])
            );
        end
        else
        begin : g_body
            tklt_cell #(.IS_LOW(1'b0)) u_high (
                .clk(clk), .rst_n(rst_n), .load(offer_load), .en(high_en[i]),
                .cand(cand), .prev_entry(high_entry[i-1]),
                .prev_beats(high_beats[i-1]),
                .entry(high_entry[i]), .beats(high_beats[i])
            );
            tklt_cell #(.IS_LOW(1'b1)) u_low (
                .clk(clk), .rst_n(rst_n), .load(offer_load), .en(low_en[i]),
                .cand(cand), .prev_entry(low_entry[i-1]),
                .prev_beats(low_beats[i-1]),
                .entry(low_entry[i]), .beats(low_beats[i])
            );
        end
    end

    // ------------------------------------------------ insertion position
    // the first beaten cell marks the insertion point; positions are OR-ed
    logic [3:0] high_pos, low_pos;
    logic       high_ins, low_ins;

    always_comb
    begin
        high_pos = '0;
        low_pos  = '0;
        for (int i = 0; i < MAX_KEPT; i++)
        begin
            if (high_beats[i] && ((i == 0) || !high_beats[(i == 0) ? 0 : i - 1]))
                high_pos = high_pos | 4'(i);
            if (low_beats[i] && ((i == 0) || !low_beats[(i == 0) ? 0 : i - 1]))
                low_pos = low_pos | 4'(i);
        end
        high_ins = |high_beats;
        low_ins  = |low_beats;
    end

    // ---------------------------------------------------------- read select
    tklt_pkg::entry_t rd_entry;

    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < MAX_KEPT; i++)
        begin
            if ((i < 16) && (req_index == 4'(i)))
            begin
                if (req_list == tklt_pkg::LIST_LOW)
                    rd_entry = rd_entry | low_entry[i];
                else
                    rd_entry = rd_entry | high_entry[i];
            end
        end
    end

    // -------------------------------------------------------- result register
    logic        out_valid_reg, out_valid_next;
    logic [95:0] out_data_reg, out_data_next;

    assign s_tready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            unique case (req_action)
                tklt_pkg::ACT_OFFER:
                begin
                    out_data_next[0]   = high_ins;
                    out_data_next[4:1] = high_pos;
                    out_data_next[5]   = low_ins;
                    out_data_next[9:6] = low_pos;
                end
                tklt_pkg::ACT_READ:
                begin
                    out_data_next[41:10] = rd_entry.score;
                    out_data_next[73:42] = rd_entry.order;
                    out_data_next[89:74] = rd_entry.tag;
                end
                default: out_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sim/tklt_checker.sv
// ----------------------------------------------------------------------------
// tklt_checker - result checker for the top-k tracker
// Watches the configuration port and both streams, keeps its own copy of
// the two ranked lists, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tklt_checker #(
    parameter int KEPT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,  // score[31:0], order[63:32], tag[79:64],
                                  // read_index[83:80], zero[87:84]
    input  logic [1:0]  s_tuser,  // action[0], read_list[1]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,  // high_inserted[0], high_position[4:1],
                                  // low_inserted[5], low_position[9:6],
                                  // entry_score[41:10], entry_order[73:42],
                                  // entry_tag[89:74], zero[95:90]
    output int          fail_count,
    output int          outstanding
);

    typedef tklt_pkg::entry_t [KEPT-1:0] ranking_t;

    typedef struct packed {
        logic               hi_ins;
        logic [3:0]         hi_pos;
        logic               lo_ins;
        logic [3:0]         lo_pos;
        logic signed [31:0] score;
        logic signed [31:0] order;
        logic [15:0]        tag;
    } outcome_t;

    ranking_t   high_rank;
    ranking_t   low_rank;
    logic [4:0] high_count;
    logic [4:0] low_count;
    outcome_t   due_outcomes[$];
    int         fails;

    // count of 0 behaves as 1, anything above the storage depth as the depth
    function automatic int kept_len(input logic [4:0] count);
        if (count == 5'd0)
            return 1;
        if (count > KEPT)
            return KEPT;
        return int'(count);
    endfunction

    // first entry strictly beaten takes the candidate; entries behind it
    // move down one place and the last one in use falls off
    function automatic ranking_t insert_ranked(input ranking_t rank, input int len,
                                               input logic descending,
                                               input tklt_pkg::entry_t cand,
                                               output logic hit, output logic [3:0] pos);
        ranking_t r;
        logic     beats;
        r   = rank;
        hit = 1'b0;
        pos = '0;
        for (int i = 0; i < KEPT; i++)
        begin
            if (!hit && i < len)
            begin
                beats = descending ? ($signed(r[i].score) < $signed(cand.score))
                                   : ($signed(r[i].score) > $signed(cand.score));
                if (beats)
                begin
                    for (int j = KEPT - 1; j > i; j--)
                    begin
                        if (j < len)
                            r[j] = r[j-1];
                    end
                    r[i] = cand;
                    hit  = 1'b1;
                    pos  = 4'(i);
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t         want;
        outcome_t         got;
        tklt_pkg::entry_t cand;
        logic             hit;
        logic [3:0]       pos;
        if (!rst_n)
        begin
            for (int i = 0; i < KEPT; i++)
            begin
                high_rank[i] = '0;
                low_rank[i]  = '{score: tklt_pkg::LOW_SCORE_FILL,
                                 order: tklt_pkg::LOW_ORDER_FILL, tag: '0};
            end
            high_count = tklt_pkg::COUNT_RESET;
            low_count  = tklt_pkg::COUNT_RESET;
            due_outcomes.delete();
            fails        = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == tklt_pkg::REG_HIGH_COUNT)
                    high_count = cfg_wdata;
                else
                    low_count = cfg_wdata;
            end

            // results leaving at this edge belong to earlier requests
            if (m_tvalid && m_tready)
            begin
                got.hi_ins = m_tdata[0];
                got.hi_pos = m_tdata[4:1];
                got.lo_ins = m_tdata[5];
                got.lo_pos = m_tdata[9:6];
                got.score  = m_tdata[41:10];
                got.order  = m_tdata[73:42];
                got.tag    = m_tdata[89:74];
                if (due_outcomes.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fails++;
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    check_field("high_inserted", 32'(want.hi_ins), 32'(got.hi_ins));
                    check_field("high_position", 32'(want.hi_pos), 32'(got.hi_pos));
                    check_field("low_inserted", 32'(want.lo_ins), 32'(got.lo_ins));
                    check_field("low_position", 32'(want.lo_pos), 32'(got.lo_pos));
                    check_field("entry_score", want.score, got.score);
                    check_field("entry_order", want.order, got.order);
                    check_field("entry_tag", 32'(want.tag), 32'(got.tag));
                end
            end

            if (s_tvalid && s_tready)
            begin
                want = '0;
                if (s_tuser[0] == tklt_pkg::ACT_OFFER)
                begin
                    cand.score = s_tdata[31:0];
                    cand.order = s_tdata[63:32];
                    cand.tag   = s_tdata[79:64];
                    high_rank = insert_ranked(high_rank, kept_len(high_count), 1'b1,
                                              cand, hit, pos);
                    want.hi_ins = hit;
                    want.hi_pos = pos;
                    low_rank = insert_ranked(low_rank, kept_len(low_count), 1'b0,
                                             cand, hit, pos);
                    want.lo_ins = hit;
                    want.lo_pos = pos;
                end
                else if (int'(s_tdata[83:80]) < KEPT)
                begin
                    // entries past the count in use are still returned
                    cand = (s_tuser[1] == tklt_pkg::LIST_LOW) ? low_rank[s_tdata[83:80]]
                                                              : high_rank[s_tdata[83:80]];
                    want.score = cand.score;
                    want.order = cand.order;
                    want.tag   = cand.tag;
                end
                due_outcomes.push_back(want);
            end

            fail_count  <= fails;
            outstanding <= due_outcomes.size();
        end
    end

endmodule

### sim/tb_top_k_highest_lowest_tracker.sv
// ----------------------------------------------------------------------------
// tb_top_k_highest_lowest_tracker - regression bench for the top-k tracker
// Directed offers and reads around the list fill values and score extremes,
// then phases of random requests under several count settings and several
// mixes of sender gaps and receiver stalls. Checking lives in tklt_checker.
// ----------------------------------------------------------------------------
module tb_top_k_highest_lowest_tracker;

    localparam int KEPT          = 16;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 4;       // margin after draining
    localparam int CYCLE_LIMIT   = 200000;  // far above the slowest clean run

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = tklt_pkg::REG_HIGH_COUNT;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;  // score[31:0], order[63:32], tag[79:64],
                                  // read_index[83:80], zero[87:84]
    logic [1:0]  s_tuser   = '0;  // action[0], read_list[1]
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [95:0] m_tdata;         // high_inserted[0], high_position[4:1],
                                  // low_inserted[5], low_position[9:6],
                                  // entry_score[41:10], entry_order[73:42],
                                  // entry_tag[89:74], zero[95:90]

    int fail_count;
    int outstanding;
    int cycles;

    // idling mix, percent of cycles; changed per phase
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // count settings per phase, extremes and out-of-range values included
    logic [4:0] high_counts [PHASES] = '{5'd16, 5'd1, 5'd0,  5'd5,  5'd31, 5'd16, 5'd8,  5'd2};
    logic [4:0] low_counts  [PHASES] = '{5'd16, 5'd1, 5'd31, 5'd12, 5'd0,  5'd3,  5'd16, 5'd7};

    always #4 clk = ~clk;

    top_k_highest_lowest_tracker #(
        .MAX_KEPT (KEPT),
        .TAG_BITS (16)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tklt_checker #(
        .KEPT (KEPT)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // watchdog: a hang or a lost result ends here
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // One request. Idle gaps come first, so valid stays high straight into
    // the next request when no gap is drawn. Returns on the accepting edge.
    task automatic send_request(input logic act, input logic signed [31:0] score,
                                input logic signed [31:0] order, input logic [15:0] tag,
                                input logic list_sel, input logic [3:0] idx);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, idx, tag, order, score};
        s_tuser  <= {list_sel, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_offer(input logic signed [31:0] score, input logic [15:0] tag);
        send_request(tklt_pkg::ACT_OFFER, score, $urandom(), tag, 1'($urandom()),
                     4'($urandom()));
    endtask

    task automatic send_read(input logic list_sel, input logic [3:0] idx);
        send_request(tklt_pkg::ACT_READ, $urandom(), $urandom(), 16'($urandom()),
                     list_sel, idx);
    endtask

    // Stop sending and hold until every outstanding request has its result.
    // The first edge lets the checker's count catch up with the last request.
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_count(input logic addr, input logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random request. Most offers land near the top or bottom of the score
    // range, where the lists actually sit, so insertions keep hitting every
    // position; ties and extremes are drawn on purpose.
    task automatic send_random_item;
        int                 pick;
        logic signed [31:0] score;
        pick  = $urandom_range(0, 99);
        score = $urandom();
        if (pick < 30)
        begin
            send_read(1'($urandom()), 4'($urandom_range(0, 15)));
        end
        else
        begin
            if (pick < 45)
                score = 32'sh7FFF_FFFF - $urandom_range(0, 4095);
            else if (pick < 60)
                score = 32'sh8000_0000 + $urandom_range(0, 4095);
            else if (pick < 72)
            begin
                case ($urandom_range(0, 5))
                    0: score = 32'sh7FFF_FFFF;
                    1: score = 32'sh8000_0000;
                    2: score = 32'sh0000_0000;
                    3: score = -32'sd1;
                    4: score = 32'sh0001_0000;
                    default: score = 32'sh7FFF_FFF0;
                endcase
            end
            else if (pick < 82)
                score = 32'sh7FFF_FF00 + 32'($urandom_range(0, 3) * 16);
            send_offer(score, 16'($urandom()));
        end
    endtask

    initial
    begin
        int items_per_phase;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: fill values, score extremes, ties ---
        send_read(tklt_pkg::LIST_HIGH, 4'd0);
        send_read(tklt_pkg::LIST_HIGH, 4'd15);
        send_read(tklt_pkg::LIST_LOW, 4'd0);
        send_read(tklt_pkg::LIST_LOW, 4'd15);
        send_offer(32'sh0000_0000, 16'hFFFF);   // ties the zero high fill
        send_offer(32'sh7FFF_FFFF, 16'h0000);   // ties the low fill
        send_offer(32'sh8000_0000, 16'hA5A5);   // most negative score
        send_offer(-32'sd1, 16'h5A5A);
        send_offer(32'sh7FFF_FFFF, 16'h0001);   // tie stays behind the earlier one
        send_offer(32'sh8000_0000, 16'h0002);
        send_offer(32'sh0001_0000, 16'h8000);   // 1.0 in Q16.16
        send_offer(32'sh0001_0000, 16'h7FFF);
        for (int i = 0; i < 4; i++)
        begin
            send_read(tklt_pkg::LIST_HIGH, 4'(i));
            send_read(tklt_pkg::LIST_LOW, 4'(i));
        end
        send_read(tklt_pkg::LIST_HIGH, 4'd15);
        send_read(tklt_pkg::LIST_LOW, 4'd15);

        // --- random phases ---
        items_per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // registers only change with nothing in flight
            drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_count(tklt_pkg::REG_HIGH_COUNT, high_counts[ph]);
            write_count(tklt_pkg::REG_LOW_COUNT, low_counts[ph]);

            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
            endcase

            for (int n = 0; n < items_per_phase; n++)
            begin
                // mid-phase hold-off: let the result side empty completely
                if (n == items_per_phase / 2)
                    drain();
                send_random_item();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
